// ===== rtl/mts_pkg.sv =====
package mts_pkg;

    localparam int SLOTS  = 64;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SP_W   = ADDR_W + 1;

    typedef logic signed [31:0] data_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SP_W-1:0]    sp_t;

    localparam data_t MIN_EMPTY = 32'sh7FFF_FFFF;

    typedef enum logic [0:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR2,
        ST_MIN,
        ST_TOP,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/min_tracking_stack.sv =====
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+----------------------------------------
// in       | input     | in_valid / in_stall | req_type, push_value
// out      | output    | out_valid/out_stall | top_value, min_value, is_empty, status
//
// one item at a time: a single-slot push, a rejected item or a plain pop that
// empties the stack goes from IDLE to EMIT; a two-slot push goes through WR2, any
// other plain pop through TOP, and a pop that restores the minimum through MIN and,
// unless it empties the stack, TOP. the single-port stack ram sets these steps (one
// write or one read per cycle, registered read) and EMIT loads the result register.
// reset clears pointer, minimum and control; ram contents stay undefined.
// a result still stalled at the output holds the next item in its result state.
module min_tracking_stack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  mts_pkg::data_t    push_value,
    output logic              out_valid,
    input  logic              out_stall,
    output mts_pkg::data_t    top_value,
    output mts_pkg::data_t    min_value,
    output logic              is_empty,
    output logic [1:0]        status
);
    import mts_pkg::*;

    state_t  state_reg, state_next;
    sp_t     sp_reg, sp_next;
    data_t   min_reg, min_next;
    data_t   top_reg, top_next;
    status_t status_reg, status_next;

    logic    out_valid_reg, out_valid_next;
    data_t   out_top_reg, out_top_next;
    data_t   out_min_reg, out_min_next;
    logic    out_empty_reg, out_empty_next;
    status_t out_status_reg, out_status_next;

    data_t   mem [SLOTS];
    logic    wr_en;
    addr_t   wr_addr;
    data_t   wr_data;
    logic    rd_en;
    addr_t   rd_addr;
    data_t   rdata_reg;

    logic    accept;
    logic    is_pop;
    logic    need2;
    logic    overflow;
    logic    min_pop;
    logic    out_free;
    logic [SP_W:0] need_sum;
    sp_t     sp_m1;
    sp_t     sp_m2;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign is_pop   = (req_t'(req_type) == REQ_POP);
    assign need2    = (push_value <= min_reg);
    assign need_sum = {1'b0, sp_reg} + (need2 ? (SP_W+1)'(2) : (SP_W+1)'(1));
    assign overflow = (need_sum > (SP_W+1)'(SLOTS));
    // saved minimum sits right below an entry equal to the minimum
    assign min_pop  = (top_reg == min_reg) && (sp_reg >= SP_W'(2));
    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_m2    = sp_reg - SP_W'(2);
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_pop)
                        state_next = (!overflow && need2) ? ST_WR2 : ST_EMIT;
                    else if (sp_reg == '0)
                        state_next = ST_EMIT;
                    else if (min_pop)
                        state_next = ST_MIN;
                    else
                        state_next = (sp_m1 == '0) ? ST_EMIT : ST_TOP;
                end
            end
            ST_WR2: state_next = ST_EMIT;
            ST_MIN: state_next = (sp_reg == '0) ? ST_EMIT : ST_TOP;
            ST_TOP: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        sp_next         = sp_reg;
        min_next        = min_reg;
        top_next        = top_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = sp_reg[ADDR_W-1:0];
        wr_data         = top_reg;
        rd_en           = 1'b0;
        rd_addr         = sp_m2[ADDR_W-1:0];
        out_valid_next  = out_valid_reg && out_stall;
        out_top_next    = out_top_reg;
        out_min_next    = out_min_reg;
        out_empty_next  = out_empty_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_OK;
                    if (!is_pop)
                    begin
                        if (overflow)
                            status_next = STATUS_OVERFLOW;
                        else
                        begin
                            // a value at or below the minimum pushes the old minimum first
                            wr_en    = 1'b1;
                            wr_data  = need2 ? min_reg : push_value;
                            sp_next  = sp_reg + SP_W'(1);
                            top_next = push_value;
                            if (need2)
                                min_next = push_value;
                        end
                    end
                    else if (sp_reg == '0)
                        status_next = STATUS_UNDERFLOW;
                    else if (min_pop)
                    begin
                        rd_en   = 1'b1;
                        sp_next = sp_m2;
                    end
                    else
                    begin
                        sp_next = sp_m1;
                        if (sp_m1 == '0)
                            top_next = '0;
                        else
                            rd_en = 1'b1;
                    end
                end
            end
            ST_WR2:
            begin
                wr_en   = 1'b1;
                sp_next = sp_reg + SP_W'(1);
            end
            ST_MIN:
            begin
                min_next = rdata_reg;
                if (sp_reg == '0)
                    top_next = '0;
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = sp_m1[ADDR_W-1:0];
                end
            end
            ST_TOP:
            begin
                top_next = rdata_reg;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_top_next    = top_reg;
                    out_min_next    = min_reg;
                    out_empty_next  = (sp_reg == '0);
                    out_status_next = status_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            min_reg       <= MIN_EMPTY;
            top_reg       <= '0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            min_reg       <= min_next;
            top_reg       <= top_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_top_reg    <= out_top_next;
        out_min_reg    <= out_min_next;
        out_empty_reg  <= out_empty_next;
        out_status_reg <= out_status_next;
    end

    // one item in flight and the top cached in top_reg, so reads never meet writes
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign top_value = out_top_reg;
    assign min_value = out_min_reg;
    assign is_empty  = out_empty_reg;
    assign status    = out_status_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(SLOTS))
        else $error("stack pointer beyond capacity");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> (top_value == '0) && (min_value == MIN_EMPTY))
        else $error("empty beat with stale top or minimum");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

endmodule
